/* rtl/sprite_quad_batcher_unit_defines.svh */
// Assertion macros for the sprite quad batcher.
// Clocked on clk and disabled while arst_n is low; empty in synthesis.
`ifndef SPRITE_QUAD_BATCHER_UNIT_DEFINES_SVH
`define SPRITE_QUAD_BATCHER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define SQB_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("sprite quad batcher assertion failed");
`define SQB_NEVER(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(prop)) \
		else $error("sprite quad batcher forbidden condition");
`else
`define SQB_ASSERT(lbl, prop)
`define SQB_NEVER(lbl, prop)
`endif
`endif

/* rtl/sqb_pkg.sv */
// Shared types and constants of the sprite quad batcher.
// No dependencies; used by every module of the block.
`default_nettype none
package sqb_pkg;
	localparam int COORD_WIDTH = 24;
	localparam int MAX_ENTRIES_DEF = 64;
	localparam int TEX_W = 32;
	localparam int IDX_W = 6;
	localparam int BATCH_W = 6;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_RUN = 1'b1;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	typedef struct packed {
		logic kind;
		logic [TEX_W-1:0] texture_id;
		coord_t top_left_x;
		coord_t top_right_x;
		coord_t top_left_y;
		coord_t bottom_left_y;
	} item_t;

	typedef struct packed {
		logic [BATCH_W-1:0] batch_number;
		logic [IDX_W-1:0] entry_index;
		logic [TEX_W-1:0] batch_texture;
		logic last;
	} result_t;

	typedef struct packed {
		logic [TEX_W-1:0] tex;
		coord_t min_x;
		coord_t max_x;
		coord_t min_y;
		coord_t max_y;
	} entry_t;

	typedef struct packed {
		logic wr_en;
		logic [IDX_W-1:0] wr_addr;
		logic rd_en;
		logic [IDX_W-1:0] rd_addr;
	} mem_req_t;
endpackage
`default_nettype wire

/* rtl/sqb_store.sv */
// Quad store: one synchronous memory holding texture and bounding box per entry.
// Depends on sqb_pkg; the box is formed from the corners on the write side.
`default_nettype none
module sqb_store import sqb_pkg::*; #(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
	input  wire logic     clk,
	input  wire mem_req_t req,
	input  wire item_t    wr_item,
	output entry_t        rd_data
);
	localparam int IW = $clog2(MAX_ENTRIES);

	entry_t mem [MAX_ENTRIES];
	entry_t wr_entry;

	always_comb begin
		wr_entry.tex = wr_item.texture_id;
		if (wr_item.top_left_x < wr_item.top_right_x) begin
			wr_entry.min_x = wr_item.top_left_x;
			wr_entry.max_x = wr_item.top_right_x;
		end else begin
			wr_entry.min_x = wr_item.top_right_x;
			wr_entry.max_x = wr_item.top_left_x;
		end
		if (wr_item.top_left_y < wr_item.bottom_left_y) begin
			wr_entry.min_y = wr_item.top_left_y;
			wr_entry.max_y = wr_item.bottom_left_y;
		end else begin
			wr_entry.min_y = wr_item.bottom_left_y;
			wr_entry.max_y = wr_item.top_left_y;
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr[IW-1:0]] <= wr_entry;
		end
		if (req.rd_en) begin
			rd_data <= mem[req.rd_addr[IW-1:0]];
		end
	end
endmodule
`default_nettype wire

/* rtl/sqb_seq.sv */
// Batching sequencer: entry count, assigned flags and the greedy scan.
// Depends on sqb_pkg and the assertion macros; drives the quad store.
`default_nettype none
`include "sprite_quad_batcher_unit_defines.svh"
module sqb_seq import sqb_pkg::*; #(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   start,
	input  wire logic   kind,
	output logic        busy,
	output mem_req_t    req,
	input  wire entry_t rd_data,
	output logic        result_valid,
	output result_t     result
);
	localparam int IW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES + 1);

	typedef enum logic [2:0] {
		S_IDLE, S_TEX_RD, S_TEX_WAIT, S_SCAN, S_I_WAIT, S_J_LOOP, S_J_WAIT
	} state_t;

	state_t state_q;
	logic [CW-1:0] count_q, left_q, begin_q, i_q, j_q;
	logic first_q, gathered_q;
	logic [BATCH_W-1:0] batch_q;
	logic [TEX_W-1:0] tex_q;
	entry_t box_q;
	logic [MAX_ENTRIES-1:0] assigned_q;
	logic res_valid_q;
	result_t res_q;

	logic i_in_range, i_assigned, j_assigned, apart;

	assign i_in_range = i_q < count_q;
	assign i_assigned = assigned_q[i_q[IW-1:0]];
	assign j_assigned = assigned_q[j_q[IW-1:0]];
	// Touching edges overlap: boxes are apart only on a strict gap.
	assign apart = (box_q.max_x < rd_data.min_x) || (rd_data.max_x < box_q.min_x) ||
		(box_q.max_y < rd_data.min_y) || (rd_data.max_y < box_q.min_y);

	assign busy = state_q != S_IDLE;
	assign result_valid = res_valid_q;
	assign result = res_q;

	always_comb begin
		req.wr_en = (state_q == S_IDLE) && start && (kind == KIND_LOAD) &&
			(count_q < CW'(MAX_ENTRIES));
		req.wr_addr = IDX_W'(count_q);
		req.rd_en = 1'b0;
		req.rd_addr = IDX_W'(begin_q);
		case (state_q)
			S_TEX_RD: begin
				req.rd_en = 1'b1;
			end
			S_SCAN: begin
				req.rd_en = i_in_range && !i_assigned;
				req.rd_addr = IDX_W'(i_q);
			end
			S_J_LOOP: begin
				req.rd_en = (j_q != i_q) && !j_assigned;
				req.rd_addr = IDX_W'(j_q);
			end
			default: begin
				req.rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			left_q <= '0;
			begin_q <= '0;
			i_q <= '0;
			j_q <= '0;
			first_q <= 1'b0;
			gathered_q <= 1'b0;
			batch_q <= '0;
			assigned_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (req.wr_en) begin
						count_q <= count_q + 1'b1;
					end else if (start && kind == KIND_RUN && count_q != '0) begin
						left_q <= count_q;
						begin_q <= '0;
						batch_q <= '0;
						state_q <= S_TEX_RD;
					end
				end
				S_TEX_RD: begin
					state_q <= S_TEX_WAIT;
				end
				S_TEX_WAIT: begin
					tex_q <= rd_data.tex;
					i_q <= begin_q;
					first_q <= 1'b1;
					gathered_q <= 1'b0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (!i_in_range) begin
						if (gathered_q) begin
							batch_q <= batch_q + 1'b1;
						end
						if (left_q == '0) begin
							assigned_q <= '0;
							count_q <= '0;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_TEX_RD;
						end
					end else if (i_assigned) begin
						i_q <= i_q + 1'b1;
					end else begin
						if (first_q) begin
							begin_q <= i_q;
						end
						first_q <= 1'b0;
						state_q <= S_I_WAIT;
					end
				end
				S_I_WAIT: begin
					if (rd_data.tex != tex_q) begin
						i_q <= i_q + 1'b1;
						state_q <= S_SCAN;
					end else begin
						box_q <= rd_data;
						j_q <= begin_q;
						state_q <= S_J_LOOP;
					end
				end
				S_J_LOOP: begin
					if (j_q == i_q) begin
						res_valid_q <= 1'b1;
						res_q.batch_number <= batch_q;
						res_q.entry_index <= IDX_W'(i_q);
						res_q.batch_texture <= tex_q;
						res_q.last <= left_q == CW'(1);
						assigned_q[i_q[IW-1:0]] <= 1'b1;
						if (i_q == begin_q) begin
							begin_q <= begin_q + 1'b1;
						end
						left_q <= left_q - 1'b1;
						gathered_q <= 1'b1;
						i_q <= i_q + 1'b1;
						state_q <= S_SCAN;
					end else if (j_assigned) begin
						j_q <= j_q + 1'b1;
					end else begin
						state_q <= S_J_WAIT;
					end
				end
				S_J_WAIT: begin
					if (!apart) begin
						i_q <= i_q + 1'b1;
						state_q <= S_SCAN;
					end else begin
						j_q <= j_q + 1'b1;
						state_q <= S_J_LOOP;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`SQB_ASSERT(a_result_in_run, res_valid_q |-> state_q == S_SCAN)
	`SQB_ASSERT(a_last_drains, (res_valid_q && res_q.last) |-> left_q == '0)
	`SQB_ASSERT(a_left_bounded, busy |-> left_q <= count_q)
	`SQB_NEVER(a_j_below_i, state_q == S_J_WAIT && j_q >= i_q)
endmodule
`default_nettype wire

/* rtl/sprite_quad_batcher_unit.sv */
// channel   | handshake                 | payload
// ----------+---------------------------+----------------
// item in   | start & !busy             | item   (item_t)
// result    | result_valid, one cycle   | result (result_t)
//
// A load keeps busy low, so loads can arrive every cycle.
// A run reads the texture of each batch from its first unassigned quad, then scans from there,
// skipping assigned quads. A quad of the batch texture joins the batch unless an earlier
// unassigned quad overlaps it; every step uses the single read port of the quad memory.
// A run over an empty store yields no result, and busy stays low.
// Reset clears the entry count and assigned flags; the memory needs no clearing.
// The receiver cannot stall: each result shows for exactly one cycle.
`default_nettype none
module sprite_quad_batcher_unit import sqb_pkg::*; #(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  start,
	input  wire item_t item,
	output logic       busy,
	output logic       result_valid,
	output result_t    result
);
	mem_req_t req;
	entry_t rd_data;

	sqb_store #(.MAX_ENTRIES(MAX_ENTRIES)) u_store (
		.clk(clk),
		.req(req),
		.wr_item(item),
		.rd_data(rd_data)
	);

	sqb_seq #(.MAX_ENTRIES(MAX_ENTRIES)) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.kind(item.kind),
		.busy(busy),
		.req(req),
		.rd_data(rd_data),
		.result_valid(result_valid),
		.result(result)
	);
endmodule
`default_nettype wire

/* verif/sprite_quad_batcher_unit_tb.sv */
// Testbench for the sprite quad batcher: loads quads, runs batching, and checks
// every result against a built-in predictor. Depends on sqb_pkg and the unit.
`timescale 1ns / 1ps
`default_nettype none

class batch_scoreboard;
	sqb_pkg::result_t pending_results[$];
	int errors;
	int checked;
	logic [31:0] tex_mem [64];
	logic signed [23:0] lo_x [64];
	logic signed [23:0] hi_x [64];
	logic signed [23:0] lo_y [64];
	logic signed [23:0] hi_y [64];
	int quad_count;

	function bit apart(int a, int b);
		return hi_x[a] < lo_x[b] || hi_x[b] < lo_x[a] ||
			hi_y[a] < lo_y[b] || hi_y[b] < lo_y[a];
	endfunction

	// Notes one accepted transaction and queues the results it will cause.
	function void note_item(sqb_pkg::item_t it);
		bit taken [64];
		int left, head, batch, gathered, i, j;
		bit first, ok;
		logic [31:0] tex;
		sqb_pkg::result_t r;
		if (it.kind == sqb_pkg::KIND_LOAD) begin
			if (quad_count >= 64)
				return;
			tex_mem[quad_count] = it.texture_id;
			lo_x[quad_count] = (it.top_left_x < it.top_right_x) ? it.top_left_x : it.top_right_x;
			hi_x[quad_count] = (it.top_left_x < it.top_right_x) ? it.top_right_x : it.top_left_x;
			lo_y[quad_count] = (it.top_left_y < it.bottom_left_y) ?
				it.top_left_y : it.bottom_left_y;
			hi_y[quad_count] = (it.top_left_y < it.bottom_left_y) ?
				it.bottom_left_y : it.top_left_y;
			quad_count++;
			return;
		end
		foreach (taken[k])
			taken[k] = 0;
		left = quad_count;
		head = 0;
		batch = 0;
		while (left > 0 && head < quad_count) begin
			tex = tex_mem[head];
			first = 1;
			gathered = 0;
			for (i = head; i < quad_count; i++) begin
				if (taken[i])
					continue;
				if (first)
					head = i;
				first = 0;
				if (tex_mem[i] != tex)
					continue;
				ok = 1;
				for (j = i - 1; j >= head; j--) begin
					if (taken[j])
						continue;
					if (!apart(i, j)) begin
						ok = 0;
						break;
					end
				end
				if (ok) begin
					r.batch_number = batch[5:0];
					r.entry_index = i[5:0];
					r.batch_texture = tex;
					r.last = (left == 1);
					pending_results = {pending_results, r};
					taken[i] = 1;
					if (i == head)
						head++;
					left--;
					gathered++;
				end
			end
			if (gathered > 0)
				batch++;
		end
		// The final flag goes on the last queued result of this run.
		if (left != quad_count)
			pending_results[$].last = 1;
		quad_count = 0;
	endfunction

	function void check_result(sqb_pkg::result_t got);
		sqb_pkg::result_t exp_r;
		checked++;
		if (pending_results.size() == 0) begin
			$display("%0t: unexpected result %p", $time, got);
			errors++;
			return;
		end
		exp_r = pending_results.pop_front();
		if (exp_r.batch_number !== got.batch_number)
			$display("%0t: batch_number expected %0d actual %0d", $time,
				exp_r.batch_number, got.batch_number);
		if (exp_r.entry_index !== got.entry_index)
			$display("%0t: entry_index expected %0d actual %0d", $time,
				exp_r.entry_index, got.entry_index);
		if (exp_r.batch_texture !== got.batch_texture)
			$display("%0t: batch_texture expected %h actual %h", $time,
				exp_r.batch_texture, got.batch_texture);
		if (exp_r.last !== got.last)
			$display("%0t: last expected %0d actual %0d", $time, exp_r.last, got.last);
		if (exp_r !== got)
			errors++;
	endfunction
endclass

module sprite_quad_batcher_unit_tb;
	import sqb_pkg::*;

	localparam int STALL_LIMIT = 200000;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	item_t item = '0;
	logic busy;
	logic result_valid;
	result_t result;

	batch_scoreboard sb;
	int idle_cycles = 0;
	int loads_sent;
	int runs_sent;
	bit gaps_on;

	sprite_quad_batcher_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.item(item),
		.busy(busy),
		.result_valid(result_valid),
		.result(result)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && result_valid)
			sb.check_result(result);
		if (arst_n && ((start && !busy) || result_valid))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	always @(posedge clk) begin
		if (idle_cycles > STALL_LIMIT) begin
			$display("watchdog expired");
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic logic signed [23:0] pick_coord(int mode);
		case (mode)
			0: return 24'sh800000;
			1: return 24'sh7fffff;
			2: return 24'($signed($urandom_range(0, 4000)) - 2000);
			default: return 24'($urandom);
		endcase
	endfunction

	// Holds start through one accepted transaction, with random gaps before it when gaps_on is set.
	task automatic send(item_t it);
		if (gaps_on)
			while ($urandom_range(0, 99) < 35) begin
				start <= 0;
				@(posedge clk);
			end
		start <= 1;
		item <= it;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_item(it);
		if (it.kind == KIND_LOAD)
			loads_sent++;
		else
			runs_sent++;
	endtask

	// Drops start so that no transaction is pending while waiting.
	task automatic stop_driving();
		start <= 0;
		@(posedge clk);
	endtask

	task automatic send_quad(logic [31:0] tex, logic signed [23:0] x0, logic signed [23:0] x1,
			logic signed [23:0] y0, logic signed [23:0] y1);
		item_t it;
		it.kind = KIND_LOAD;
		it.texture_id = tex;
		it.top_left_x = x0;
		it.top_right_x = x1;
		it.top_left_y = y0;
		it.bottom_left_y = y1;
		send(it);
	endtask

	task automatic send_run();
		item_t it;
		it.kind = KIND_RUN;
		it.texture_id = $urandom;
		it.top_left_x = pick_coord(3);
		it.top_right_x = pick_coord(3);
		it.top_left_y = pick_coord(3);
		it.bottom_left_y = pick_coord(3);
		send(it);
	endtask

	task automatic send_random_quad(int n_tex);
		int m;
		logic [31:0] tex;
		m = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : 2;
		tex = (n_tex == 0) ? $urandom : 32'(1000 + $urandom_range(0, n_tex - 1));
		send_quad(tex, pick_coord(m), pick_coord(m), pick_coord(m), pick_coord(m));
	endtask

	initial begin
		int n;
		sb = new();
		gaps_on = 1;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Empty run, touching edges, disjoint boxes and extreme values.
		send_run();
		send_quad(32'h0, 0, 100, 0, 100);
		send_quad(32'h0, 100, 200, 0, 100);
		send_quad(32'hffffffff, 24'sh800000, 24'sh7fffff, 24'sh800000, 24'sh7fffff);
		send_quad(32'h0, 300, 400, 101, 200);
		send_quad(32'hffffffff, 500, 400, 900, 800);
		send_quad(32'h0, 401, 500, 0, 50);
		send_run();
		// Two interleaved textures, so the second batch passes over an entry already assigned to the first.
		send_quad(32'h5, 0, 10, 0, 10);
		send_quad(32'h6, 0, 10, 0, 10);
		send_quad(32'h5, 20, 30, 20, 30);
		send_quad(32'h6, 40, 50, 40, 50);
		send_run();
		// Full store, then loads that must be ignored.
		for (int k = 0; k < 67; k++)
			send_random_quad(3);
		send_run();

		// Pause until every expected result has come back.
		stop_driving();
		while (sb.pending_results.size() != 0)
			@(posedge clk);

		while (loads_sent + runs_sent < 375) begin
			gaps_on = !(loads_sent + runs_sent > 200 && loads_sent + runs_sent < 260);
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 64) : $urandom_range(1, 10);
			for (int k = 0; k < n; k++)
				send_random_quad($urandom_range(0, 4));
			send_run();
		end
		gaps_on = 1;
		stop_driving();

		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		$display("Sent %0d loads and %0d runs, checked %0d results.",
			loads_sent, runs_sent, sb.checked);
		if (sb.errors == 0 && sb.pending_results.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule

`default_nettype wire
